// ===== rtl/core/lsms_pkg.sv =====
// Shared types, constants and codes for the LCD scanline mode sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lsms_pkg;

  // Fixed field widths
  localparam int unsigned CyclesW   = 5;
  localparam int unsigned LineW     = 8;
  localparam int unsigned DotW      = 10;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;

  // Default line length in dots
  localparam int unsigned DotsPerLineDef = 456;

  // Dot thresholds inside one line
  localparam logic [DotW:0] OamEndDot  = (DotW+1)'(80);
  localparam logic [DotW:0] XferEndDot = (DotW+1)'(252);

  // Line thresholds inside one frame
  localparam logic [LineW-1:0] VblankLine   = LineW'(144);
  localparam logic [LineW-1:0] RenderLimit  = LineW'(145);
  localparam logic [LineW-1:0] LastLine     = LineW'(154);
  localparam logic [LineW-1:0] MaxLineSeen  = LineW'(155);

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DISPLAY_ENABLE = 3'd0,
    REG_LINE_COMPARE   = 3'd1,
    REG_HBLANK_IRQ_EN  = 3'd2,
    REG_VBLANK_IRQ_EN  = 3'd3,
    REG_OAM_IRQ_EN     = 3'd4,
    REG_COMPARE_IRQ_EN = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             display_enable;
    logic [LineW-1:0] line_compare;
    logic             hblank_irq_enable;
    logic             vblank_irq_enable;
    logic             oam_irq_enable;
    logic             compare_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [DotW-1:0]  dot_count;
    logic [LineW-1:0] line_number;
    lcd_mode_e        mode;
    lcd_mode_e        prev_mode;
    logic             line_rendered;
    logic             frame_shown;
  } seq_state_t;

  typedef struct packed {
    lcd_mode_e        lcd_mode;
    logic             line_match;
    logic             status_irq;
    logic             frame_irq;
    logic             render_line_strobe;
    logic             frame_ready_strobe;
    logic [LineW-1:0] current_line;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lsms_intf.sv =====
// Valid/ready channel interfaces for input requests, results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface lsms_in_if import lsms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CyclesW-1:0] elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface lsms_out_if import lsms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       lcd_mode;
  logic             line_match;
  logic             status_irq;
  logic             frame_irq;
  logic             render_line_strobe;
  logic             frame_ready_strobe;
  logic [LineW-1:0] current_line;

  modport source (
    output valid, output lcd_mode, output line_match, output status_irq,
    output frame_irq, output render_line_strobe, output frame_ready_strobe,
    output current_line, input ready
  );
  modport sink (
    input valid, input lcd_mode, input line_match, input status_irq,
    input frame_irq, input render_line_strobe, input frame_ready_strobe,
    input current_line, output ready
  );
endinterface

interface lsms_cfg_if import lsms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lsms_cfg_regs.sv =====
// Configuration register file written over the register write channel.
`timescale 1ns / 1ps
`default_nettype none

module lsms_cfg_regs import lsms_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  lsms_cfg_if.sink    cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Always take register writes
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_DISPLAY_ENABLE: cfg_d.display_enable     = cfg_i.wdata[0];
        REG_LINE_COMPARE:   cfg_d.line_compare       = cfg_i.wdata[LineW-1:0];
        REG_HBLANK_IRQ_EN:  cfg_d.hblank_irq_enable  = cfg_i.wdata[0];
        REG_VBLANK_IRQ_EN:  cfg_d.vblank_irq_enable  = cfg_i.wdata[0];
        REG_OAM_IRQ_EN:     cfg_d.oam_irq_enable     = cfg_i.wdata[0];
        REG_COMPARE_IRQ_EN: cfg_d.compare_irq_enable = cfg_i.wdata[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/lsms_step.sv =====
// Per-request update: dot add, mode selection, interrupts, strobes, line advance.
`timescale 1ns / 1ps
`default_nettype none

module lsms_step import lsms_pkg::*; #(
  parameter int unsigned DOTS_PER_LINE = DotsPerLineDef
) (
  input  wire [CyclesW-1:0] cycles_i,
  input  cfg_t              cfg_i,
  input  seq_state_t        state_i,
  output seq_state_t        state_o,
  output result_t           result_o
);

  localparam logic [DotW:0] LineEndDot = (DotW+1)'(DOTS_PER_LINE);

  logic [DotW:0]    dots;
  logic [DotW:0]    dots_wrap;
  logic [LineW-1:0] line;
  logic             in_oam, in_xfer, in_hblank, past_end;
  logic             in_vblank;
  logic             match;
  lcd_mode_e        mode_mid, prev_mid;
  logic             irq_mode;

  // Four dots per machine cycle
  assign dots      = {1'b0, state_i.dot_count} + {{(DotW-CyclesW-1){1'b0}}, cycles_i, 2'b00};
  assign dots_wrap = dots - LineEndDot;
  assign line      = state_i.line_number;

  assign in_oam    = (dots <= OamEndDot);
  assign in_xfer   = !in_oam && (dots <= XferEndDot);
  assign in_hblank = !in_oam && !in_xfer && (dots <= LineEndDot);
  assign past_end  = (dots > LineEndDot);
  assign in_vblank = (line >= VblankLine);
  assign match     = (line == cfg_i.line_compare) && cfg_i.compare_irq_enable;

  // Select mode by dot position, then let vertical blank override it
  always_comb begin
    mode_mid = state_i.mode;
    prev_mid = state_i.prev_mode;
    irq_mode = 1'b0;
    priority if (in_oam) begin
      mode_mid = MODE_OAM;
      irq_mode = (state_i.prev_mode != MODE_OAM) && cfg_i.oam_irq_enable;
      prev_mid = MODE_OAM;
    end else if (in_xfer) begin
      mode_mid = MODE_XFER;
    end else if (in_hblank) begin
      mode_mid = MODE_HBLANK;
      irq_mode = (state_i.prev_mode != MODE_HBLANK) && cfg_i.hblank_irq_enable;
      prev_mid = MODE_HBLANK;
    end else begin
      mode_mid = state_i.mode;
    end

    result_o.lcd_mode   = mode_mid;
    state_o.mode        = mode_mid;
    state_o.prev_mode   = prev_mid;
    result_o.status_irq = irq_mode || match;
    if (in_vblank) begin
      result_o.lcd_mode = MODE_VBLANK;
      state_o.mode      = MODE_VBLANK;
      state_o.prev_mode = MODE_VBLANK;
      if ((prev_mid != MODE_VBLANK) && cfg_i.vblank_irq_enable) begin
        result_o.status_irq = 1'b1;
      end
    end

    // Strobes, line advance and frame wrap
    result_o.render_line_strobe = !state_i.line_rendered && !in_oam && !in_xfer &&
                                  (line < RenderLimit);
    result_o.frame_irq          = !state_i.frame_shown && (line == VblankLine) &&
                                  cfg_i.display_enable;
    result_o.frame_ready_strobe = result_o.frame_irq;
    result_o.line_match         = match;
    result_o.current_line       = line;

    state_o.line_rendered = state_i.line_rendered || result_o.render_line_strobe;
    state_o.frame_shown   = state_i.frame_shown || result_o.frame_irq;
    state_o.line_number   = line;
    state_o.dot_count     = dots[DotW-1:0];
    if (past_end) begin
      state_o.dot_count     = dots_wrap[DotW-1:0];
      state_o.line_number   = line + LineW'(1);
      state_o.line_rendered = 1'b0;
    end
    if (line > LastLine) begin
      state_o.line_number = '0;
      state_o.frame_shown = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcd_scanline_mode_sequencer_top.sv =====
// Top level of the LCD scanline mode sequencer: input register, state, result register.
// A request is held in the input register, then its result in the result register,
// which keeps an untaken result and holds back the request behind it.
// Throughput: one request per cycle while results are taken; an empty input register
// takes a request even while a result waits untaken, and the state advances per request.
// Reset (rst_ni low, asynchronous): state, configuration and valid flags clear to zero.
`timescale 1ns / 1ps
`default_nettype none

module lcd_scanline_mode_sequencer_top import lsms_pkg::*; #(
  parameter int unsigned DOTS_PER_LINE = DotsPerLineDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  lsms_in_if.sink    in_req_i,
  lsms_out_if.source res_o,
  lsms_cfg_if.sink   cfg_i
);

  localparam logic [DotW:0] LineEndDot = (DotW+1)'(DOTS_PER_LINE);

  cfg_t               cfg;
  logic               in_valid_q, in_valid_d;
  logic [CyclesW-1:0] in_cycles_q;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, step_res;
  seq_state_t         state_q, state_d;
  logic               in_accept, advance;

  lsms_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lsms_step #(
    .DOTS_PER_LINE (DOTS_PER_LINE)
  ) u_step (
    .cycles_i (in_cycles_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // Move the held request on whenever the result register is free or drains
  assign advance        = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_req_i.ready = !in_valid_q || advance;
  assign in_accept      = in_req_i.valid && in_req_i.ready;
  assign in_valid_d     = in_accept || (in_valid_q && !advance);
  assign out_valid_d    = advance || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Hold payloads; no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_cycles_q <= in_req_i.elapsed_cycles;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.lcd_mode           = out_q.lcd_mode;
  assign res_o.line_match         = out_q.line_match;
  assign res_o.status_irq         = out_q.status_irq;
  assign res_o.frame_irq          = out_q.frame_irq;
  assign res_o.render_line_strobe = out_q.render_line_strobe;
  assign res_o.frame_ready_strobe = out_q.frame_ready_strobe;
  assign res_o.current_line       = out_q.current_line;

  // Dot counter always comes back within one line
  a_dot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, state_q.dot_count} <= LineEndDot))
    else $error("dot counter past line end");

  // Lines run from 0 up to one past the last frame line
  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.line_number <= MaxLineSeen))
    else $error("line number out of range");

  // Sequencer state moves only when a request is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a request");

  // A frame interrupt only comes out in vertical blank
  a_frame_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_irq) |-> (out_q.lcd_mode == MODE_VBLANK))
    else $error("frame interrupt outside vertical blank");

  // An untaken result is not overwritten
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result lost");

endmodule

`default_nettype wire
